>>> sv/grte_pkg.sv
// ----------------------------------------------------------------------------
// grte_pkg
// Shared types, character codes and helpers for the geometry record text
// extractor.
// ----------------------------------------------------------------------------
package grte_pkg;

	localparam logic [7:0] CH_BSLASH = 8'd92;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NONE   = 8'h00;

	localparam int unsigned PAD_W     = 5;
	localparam int unsigned COL_W     = 8;
	localparam logic [PAD_W-1:0] PAD_RESET = 5'd12;
	localparam logic [PAD_W-1:0] PAD_LIMIT = 5'd16;
	localparam logic [PAD_W-1:0] CHARS_MAX = 5'd31;
	localparam logic [COL_W-1:0] COL_MAX   = 8'd255;
	localparam logic [COL_W-1:0] COL_RESET = 8'd1;

	// parse phase, one-hot
	typedef enum logic [8:0] {
		PH_HUNT   = 9'b0_0000_0001,
		PH_SECOND = 9'b0_0000_0010,
		PH_SIGN   = 9'b0_0000_0100,
		PH_MINUS  = 9'b0_0000_1000,
		PH_COMMA  = 9'b0_0001_0000,
		PH_SPIN   = 9'b0_0010_0000,
		PH_CLOSE  = 9'b0_0100_0000,
		PH_BODY   = 9'b0_1000_0000,
		PH_NUMBER = 9'b1_0000_0000
	} phase_t;

	// controller states, one-hot
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_PAD  = 3'b010,
		S_TAIL = 3'b100
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic emit_pad;
		logic emit_tail_now;
		logic emit_tail_q;
	} ctrl_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic has_pads;
		logic has_tail;
		logic pad_last;
	} dp_sts_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return b inside {[8'h41:8'h5a], [8'h61:8'h7a]};
	endfunction

endpackage

>>> sv/grte_ctrl.sv
// ----------------------------------------------------------------------------
// grte_ctrl
// Sequencer: takes requests, then plays out zero pads and the closing
// character through the output register.
// ----------------------------------------------------------------------------
module grte_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  grte_pkg::dp_sts_t  sts,
	output grte_pkg::ctrl_cmd_t cmd
);

	grte_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grte_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = !((state_q == grte_pkg::S_IDLE) && sts.slot_free);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			grte_pkg::S_IDLE: begin
				if (in_valid && sts.slot_free) begin
					cmd.accept = 1'b1;
					if (sts.has_pads) begin
						state_d = grte_pkg::S_PAD;
					end else begin
						// single result goes straight to the output register
						cmd.emit_tail_now = sts.has_tail;
					end
				end
			end
			grte_pkg::S_PAD: begin
				if (sts.slot_free) begin
					cmd.emit_pad = 1'b1;
					if (sts.pad_last) begin
						state_d = grte_pkg::S_TAIL;
					end
				end
			end
			grte_pkg::S_TAIL: begin
				if (sts.slot_free) begin
					cmd.emit_tail_q = 1'b1;
					state_d         = grte_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = grte_pkg::S_IDLE;
			end
		endcase
	end

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_pad, cmd.emit_tail_now, cmd.emit_tail_q}))
		else $error("more than one output load in a cycle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_pad || cmd.emit_tail_now || cmd.emit_tail_q) |-> sts.slot_free)
		else $error("output load while slot busy");

	a_pad_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.has_pads) |=> (state_q == grte_pkg::S_PAD))
		else $error("padding request did not start pad sequence");

endmodule

>>> sv/grte_dp.sv
// ----------------------------------------------------------------------------
// grte_dp
// Datapath: header/body parse state, byte decode, pad counter, pending
// closing character and the output register.
// ----------------------------------------------------------------------------
module grte_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [4:0]          cfg_data,
	input  logic [7:0]          in_byte,
	input  logic                end_of_input,
	input  logic                out_stall,
	input  grte_pkg::ctrl_cmd_t cmd,
	output grte_pkg::dp_sts_t   sts,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	output logic                is_last,
	output logic                parse_error,
	output logic [7:0]          column_count
);

	logic [grte_pkg::PAD_W-1:0] pad_width_q;
	grte_pkg::phase_t           phase_q, phase_d;
	logic [grte_pkg::PAD_W-1:0] chars_q, chars_d;
	logic [grte_pkg::COL_W-1:0] cols_q, cols_d;
	logic                       counting_q, counting_d;

	logic [grte_pkg::PAD_W-1:0] pad_rem_q, pads_d;
	logic [7:0]                 tail_byte_q, tail_byte_d;
	logic                       tail_last_q, tail_last_d;
	logic                       tail_err_q, tail_err_d;
	logic [grte_pkg::COL_W-1:0] tail_cols_q, tail_cols_d;
	logic                       tail_vld_d;

	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       out_last_q;
	logic                       out_err_q;
	logic [grte_pkg::COL_W-1:0] out_cols_q;

	logic [grte_pkg::PAD_W-1:0] pad_eff;
	logic [grte_pkg::PAD_W-1:0] pad_need;
	logic [grte_pkg::COL_W-1:0] cols_inc;

	assign pad_eff  = (pad_width_q > grte_pkg::PAD_LIMIT) ? grte_pkg::PAD_LIMIT : pad_width_q;
	assign pad_need = (chars_q < pad_eff) ? (pad_eff - chars_q) : '0;
	assign cols_inc = (counting_q && (cols_q != grte_pkg::COL_MAX)) ?
		(cols_q + 8'd1) : cols_q;

	// decode one request against the current parse state
	always_comb begin
		logic restart;
		restart     = 1'b0;
		phase_d     = phase_q;
		chars_d     = chars_q;
		cols_d      = cols_q;
		counting_d  = counting_q;
		pads_d      = '0;
		tail_vld_d  = 1'b0;
		tail_byte_d = grte_pkg::CH_NONE;
		tail_last_d = 1'b0;
		tail_err_d  = 1'b0;
		tail_cols_d = '0;
		if (end_of_input) begin
			tail_vld_d  = 1'b1;
			tail_last_d = 1'b1;
			restart     = 1'b1;
			if (phase_q == grte_pkg::PH_HUNT) begin
				tail_err_d  = 1'b1;
				tail_cols_d = cols_q;
			end else if (phase_q == grte_pkg::PH_NUMBER) begin
				pads_d      = pad_need;
				tail_byte_d = grte_pkg::CH_NL;
				tail_cols_d = cols_inc;
			end else begin
				tail_byte_d = grte_pkg::CH_NL;
				tail_cols_d = cols_q;
			end
		end else begin
			case (phase_q)
				grte_pkg::PH_HUNT: begin
					phase_d = (in_byte == grte_pkg::CH_BSLASH) ?
						grte_pkg::PH_SECOND : grte_pkg::PH_HUNT;
				end
				grte_pkg::PH_SECOND: begin
					if (!grte_pkg::is_blank(in_byte)) begin
						phase_d = (in_byte == grte_pkg::CH_BSLASH) ?
							grte_pkg::PH_SIGN : grte_pkg::PH_HUNT;
					end
				end
				grte_pkg::PH_SIGN: begin
					if (!grte_pkg::is_blank(in_byte)) begin
						if (grte_pkg::is_digit(in_byte)) begin
							phase_d = grte_pkg::PH_COMMA;
						end else if (in_byte == grte_pkg::CH_MINUS) begin
							phase_d = grte_pkg::PH_MINUS;
						end else begin
							phase_d = grte_pkg::PH_HUNT;
						end
					end
				end
				grte_pkg::PH_MINUS: begin
					// no blank allowed between sign and digit
					phase_d = grte_pkg::is_digit(in_byte) ?
						grte_pkg::PH_COMMA : grte_pkg::PH_HUNT;
				end
				grte_pkg::PH_COMMA: begin
					if (!grte_pkg::is_blank(in_byte)) begin
						phase_d = (in_byte == grte_pkg::CH_COMMA) ?
							grte_pkg::PH_SPIN : grte_pkg::PH_HUNT;
					end
				end
				grte_pkg::PH_SPIN: begin
					if (!grte_pkg::is_blank(in_byte)) begin
						phase_d = grte_pkg::is_digit(in_byte) ?
							grte_pkg::PH_CLOSE : grte_pkg::PH_HUNT;
					end
				end
				grte_pkg::PH_CLOSE: begin
					if (!grte_pkg::is_blank(in_byte)) begin
						phase_d = (in_byte == grte_pkg::CH_BSLASH) ?
							grte_pkg::PH_BODY : grte_pkg::PH_HUNT;
					end
				end
				grte_pkg::PH_BODY: begin
					if (in_byte == grte_pkg::CH_BSLASH) begin
						tail_vld_d  = 1'b1;
						tail_byte_d = grte_pkg::CH_NL;
						tail_last_d = 1'b1;
						tail_cols_d = cols_q;
						restart     = 1'b1;
					end else if (grte_pkg::is_letter(in_byte)) begin
						tail_vld_d  = 1'b1;
						tail_byte_d = in_byte;
					end else if (in_byte == grte_pkg::CH_COMMA) begin
						tail_vld_d  = 1'b1;
						tail_byte_d = grte_pkg::CH_TAB;
					end else if (grte_pkg::is_digit(in_byte) ||
							(in_byte == grte_pkg::CH_MINUS)) begin
						tail_vld_d  = 1'b1;
						tail_byte_d = in_byte;
						chars_d     = 5'd1;
						phase_d     = grte_pkg::PH_NUMBER;
					end
				end
				grte_pkg::PH_NUMBER: begin
					if (grte_pkg::is_blank(in_byte)) begin
						phase_d = grte_pkg::PH_NUMBER;
					end else if ((in_byte == grte_pkg::CH_COMMA) ||
							(in_byte == grte_pkg::CH_BSLASH)) begin
						pads_d     = pad_need;
						cols_d     = cols_inc;
						chars_d    = '0;
						tail_vld_d = 1'b1;
						phase_d    = grte_pkg::PH_BODY;
						if (in_byte == grte_pkg::CH_BSLASH) begin
							// end of first line stops the column count
							tail_byte_d = grte_pkg::CH_NL;
							counting_d  = 1'b0;
						end else begin
							tail_byte_d = grte_pkg::CH_TAB;
						end
					end else begin
						tail_vld_d  = 1'b1;
						tail_byte_d = in_byte;
						if (chars_q != grte_pkg::CHARS_MAX) begin
							chars_d = chars_q + 5'd1;
						end
					end
				end
				default: begin
					phase_d = grte_pkg::PH_HUNT;
				end
			endcase
		end
		if (restart) begin
			phase_d    = grte_pkg::PH_HUNT;
			chars_d    = '0;
			cols_d     = grte_pkg::COL_RESET;
			counting_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_width_q <= grte_pkg::PAD_RESET;
			phase_q     <= grte_pkg::PH_HUNT;
			chars_q     <= '0;
			cols_q      <= grte_pkg::COL_RESET;
			counting_q  <= 1'b1;
			pad_rem_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				pad_width_q <= cfg_data;
			end
			if (cmd.accept) begin
				phase_q    <= phase_d;
				chars_q    <= chars_d;
				cols_q     <= cols_d;
				counting_q <= counting_d;
				pad_rem_q  <= pads_d;
			end else if (cmd.emit_pad) begin
				pad_rem_q <= pad_rem_q - 5'd1;
			end
			if (cmd.emit_pad || cmd.emit_tail_now || cmd.emit_tail_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tail_byte_q <= tail_byte_d;
			tail_last_q <= tail_last_d;
			tail_err_q  <= tail_err_d;
			tail_cols_q <= tail_cols_d;
		end
		if (cmd.emit_pad) begin
			out_byte_q <= grte_pkg::CH_ZERO;
			out_last_q <= 1'b0;
			out_err_q  <= 1'b0;
			out_cols_q <= '0;
		end else if (cmd.emit_tail_now) begin
			out_byte_q <= tail_byte_d;
			out_last_q <= tail_last_d;
			out_err_q  <= tail_err_d;
			out_cols_q <= tail_cols_d;
		end else if (cmd.emit_tail_q) begin
			out_byte_q <= tail_byte_q;
			out_last_q <= tail_last_q;
			out_err_q  <= tail_err_q;
			out_cols_q <= tail_cols_q;
		end
	end

	assign sts.slot_free = !out_valid_q || !out_stall;
	assign sts.has_pads  = (pads_d != '0);
	assign sts.has_tail  = tail_vld_d;
	assign sts.pad_last  = (pad_rem_q == 5'd1);

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign is_last      = out_last_q;
	assign parse_error  = out_err_q;
	assign column_count = out_cols_q;

	a_pad_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_pad |-> (pad_rem_q != '0))
		else $error("pad emitted with empty pad counter");

	a_count_stop_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		!counting_q |-> ((phase_q == grte_pkg::PH_BODY) || (phase_q == grte_pkg::PH_NUMBER)))
		else $error("column count stopped outside record body");

	a_cols_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_cols_q != '0))
		else $error("last result without column count");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> (out_last_q && (out_byte_q == grte_pkg::CH_NONE)))
		else $error("error result not final or carries a character");

endmodule

>>> sv/geometry_record_text_extractor.sv
// ----------------------------------------------------------------------------
// geometry_record_text_extractor
// Hunts a geometry record header in a byte stream and converts its body to
// tab separated, zero padded text.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the output register is free and no pad
// sequence runs. A comma or backslash closing a number, or end of input inside
// a number, gives max(pad_width - number characters, 0) zero pads and then a
// tab or newline, one per cycle from the pad sequencer while the output
// register is free; the input stalls until they are out. End of input while
// hunting a header returns one result with parse_error and is_last set; every
// record ends with a result carrying is_last and the column count. The user
// must write pad_width through the cfg port only while the block is idle; the
// block leaves this to the user. pad_width resets to 12; above 16 acts as 16.
module geometry_record_text_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_last,
	output logic       parse_error,
	output logic [7:0] column_count
);

	grte_pkg::ctrl_cmd_t cmd;
	grte_pkg::dp_sts_t   sts;

	assign cfg_ready = 1'b1;

	grte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	grte_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.is_last      (is_last),
		.parse_error  (parse_error),
		.column_count (column_count)
	);

endmodule
